[sv/olkd_pkg.sv]
package olkd_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [1:0] {
        CMD_APPEND       = 2'd0,
        CMD_REMOVE_HEAD  = 2'd1,
        CMD_REMOVE_MATCH = 2'd2,
        CMD_REMOVE_TAIL  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;   // register per-cell hit flags
        logic exec_en;  // apply load / shift
        cmd_t cmd;
    } cell_ctl_t;

endpackage

[sv/olkd_cell.sv]
module olkd_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  olkd_pkg::cell_ctl_t ctl,
    input  olkd_pkg::value_t    key,
    input  logic [CW-1:0]       count,
    input  olkd_pkg::value_t    next_value,
    input  logic                found_in,
    input  olkd_pkg::value_t    take_in,
    output olkd_pkg::value_t    value_out,
    output logic                found_out,
    output olkd_pkg::value_t    take_out
);
    import olkd_pkg::*;

    value_t value_reg;
    logic   hit_reg;
    logic   hit_next;
    logic   occupied;
    logic   is_tail;
    logic   first;

    assign occupied = (count > CW'(IDX));
    assign is_tail  = (count == CW'(IDX + 1));

    always_comb
    begin
        case (ctl.cmd)
            CMD_REMOVE_HEAD:  hit_next = (IDX == 0) && occupied;
            CMD_REMOVE_MATCH: hit_next = occupied && (value_reg == key);
            CMD_REMOVE_TAIL:  hit_next = is_tail;
            default:          hit_next = 1'b0;
        endcase
    end

    // Prefix chain: cells at and behind the first hit shift toward the head.
    assign found_out = found_in | hit_reg;
    assign first     = hit_reg & ~found_in;
    assign take_out  = take_in | (first ? value_reg : '0);
    assign value_out = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec_en)
        begin
            if (ctl.cmd == CMD_APPEND)
            begin
                if (count == CW'(IDX))
                begin
                    value_reg <= key;
                end
            end
            else if (found_out)
            begin
                value_reg <= next_value;
            end
        end
    end

endmodule

[sv/ordered_list_with_key_delete.sv]
// Flow: an input is captured in S_IDLE, the cells register their hit flags in
// S_CMP, and the prefix-and-shift step across the cell row commits in S_EXEC,
// which waits while a previous result waits on out_ready; the result is registered.
// A new item is accepted only in S_IDLE, after the previous item has committed.
// Reset: rst_n is asynchronous, active low; it empties the list (count zero).
// Entry contents are not cleared; slots beyond the count are never reported.
module ordered_list_with_key_delete #(
    parameter int CAPACITY = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  olkd_pkg::value_t           value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output olkd_pkg::value_t           removed_value,
    output logic [olkd_pkg::COUNT_OUT_W-1:0] entry_count
);
    import olkd_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    state_t    state_reg, state_next;
    cmd_t      cmd_reg, cmd_next;
    value_t    key_reg, key_next;
    logic [CW-1:0] count_reg, count_next;
    logic      out_valid_reg, out_valid_next;
    status_t   status_reg, status_next;
    value_t    removed_reg, removed_next;
    logic [COUNT_OUT_W-1:0] entry_count_reg, entry_count_next;

    cell_ctl_t ctl;
    logic      exec_go;
    logic      found_any;
    value_t    taken;

    // Neighbor links along the row; index CAPACITY is the open end.
    logic   found_chain [0:CAPACITY];
    value_t take_chain  [0:CAPACITY];
    value_t cell_value  [0:CAPACITY];

    assign found_chain[0] = 1'b0;
    assign take_chain[0]  = '0;
    assign cell_value[CAPACITY] = '0;

    // Result slot must be free (or draining now) before the shift commits.
    assign exec_go = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign ctl.cmp_en  = (state_reg == S_CMP);
    assign ctl.exec_en = exec_go;
    assign ctl.cmd     = cmd_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            olkd_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .key        (key_reg),
                .count      (count_reg),
                .next_value (cell_value[g+1]),
                .found_in   (found_chain[g]),
                .take_in    (take_chain[g]),
                .value_out  (cell_value[g]),
                .found_out  (found_chain[g+1]),
                .take_out   (take_chain[g+1])
            );
        end
    endgenerate

    assign found_any = found_chain[CAPACITY];
    assign taken     = take_chain[CAPACITY];

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        removed_next     = removed_reg;
        entry_count_next = entry_count_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd_t'(command);
                    key_next   = value;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    removed_next = '0;
                    if (cmd_reg == CMD_APPEND)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_DONE;
                            count_next  = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (found_any)
                    begin
                        status_next  = ST_DONE;
                        removed_next = taken;
                        count_next   = count_reg - CW'(1);
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    entry_count_next = COUNT_OUT_W'(count_next);
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= CMD_APPEND;
            key_reg         <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_DONE;
            removed_reg     <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            key_reg         <= key_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            removed_reg     <= removed_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = entry_count_reg;

endmodule
